### hw/rtl/c1ds_pkg.sv
// c1ds_pkg: item types, operation codes and controller command bundle
// for the same-size 1-D convolution unit. No dependencies.
`default_nettype none

package c1ds_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
  localparam int SAMPLE_MAX   = 2 ** (SAMPLE_WIDTH - 1) - 1;
  localparam int SAMPLE_MIN   = -(2 ** (SAMPLE_WIDTH - 1));
  localparam int ROUND_HALF   = 2 ** (SAMPLE_WIDTH - 2);

  localparam logic OP_TAP    = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic                           operation;
    logic signed [SAMPLE_WIDTH-1:0] value;
    logic                           last;
  } c1ds_in_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           end_of_block;
  } c1ds_out_t;

  // controller -> datapath
  typedef struct packed {
    logic ld_tap;     // store an incoming tap
    logic ld_smp;     // store an incoming sample
    logic issue;      // one tap/sample pair enters the MAC pipe
    logic clear_acc;  // zero the accumulator
    logic emit;       // round the accumulator into the output register
    logic last_out;   // emitted result closes the run
    logic clear_smp;  // run finished, restart sample store
  } c1ds_cmd_t;

endpackage

`default_nettype wire

### hw/rtl/c1ds_ctrl.sv
// c1ds_ctrl: sequencer for the convolution unit. Walks outputs and taps,
// drives the datapath through c1ds_cmd_t. Depends on c1ds_pkg.
`default_nettype none

module c1ds_ctrl
  import c1ds_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_TAPS    = 16,
  localparam int SAW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int SCW = $clog2(MAX_SAMPLES + 1),
  localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int TCW = $clog2(MAX_TAPS + 1),
  localparam int JW  = $clog2(MAX_SAMPLES + MAX_TAPS) + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 op_sample,
  input  wire logic                 last_flag,
  input  wire logic [TCW-1:0]       tap_cnt,
  input  wire logic [SCW-1:0]       smp_cnt,
  output logic                      busy,
  output c1ds_cmd_t                 cmd,
  output logic [TAW-1:0]            tap_addr,
  output logic signed [JW-1:0]      smp_idx
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [SAW-1:0]       k_r, k_nxt;
  logic [TAW-1:0]       t_r, t_nxt;
  logic signed [JW-1:0] j_r, j_nxt;
  logic                 d_r, d_nxt;

  logic                 accept;
  logic                 run_go;
  logic                 last_out;
  logic [TCW-1:0]       tap_cnt_m1;
  logic [TCW-1:0]       center;
  logic [SAW-1:0]       k_sel;
  logic signed [JW-1:0] j_start;
  logic [1:0]           first_st;

  assign accept     = start && (state_r == ST_IDLE);
  assign run_go     = accept && (op_sample == OP_SAMPLE) && last_flag;
  assign tap_cnt_m1 = tap_cnt - 1'b1;
  assign center     = (tap_cnt != '0) ? (tap_cnt_m1 >> 1) : '0;
  assign last_out   = (SCW'(k_r) == smp_cnt - 1'b1);
  assign k_sel      = (state_r == ST_IDLE) ? '0 : (k_r + 1'b1);
  // sample index paired with tap 0 for output k: k + center
  assign j_start    = $signed(JW'(k_sel)) + $signed(JW'(center));
  assign first_st   = (tap_cnt != '0) ? ST_ISSUE : ST_DRAIN;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    t_nxt     = t_r;
    j_nxt     = j_r;
    d_nxt     = d_r;
    unique case (state_r)
      ST_IDLE: begin
        if (run_go) begin
          k_nxt     = '0;
          t_nxt     = '0;
          j_nxt     = j_start;
          d_nxt     = 1'b0;
          state_nxt = first_st;
        end
      end
      ST_ISSUE: begin
        t_nxt = t_r + 1'b1;
        j_nxt = j_r - JW'(1);
        if (TCW'(t_r) == tap_cnt_m1) begin
          d_nxt     = 1'b0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        d_nxt = 1'b1;
        if (d_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (last_out) begin
          state_nxt = ST_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          t_nxt     = '0;
          j_nxt     = j_start;
          d_nxt     = 1'b0;
          state_nxt = first_st;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      t_r     <= '0;
      j_r     <= '0;
      d_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      t_r     <= t_nxt;
      j_r     <= j_nxt;
      d_r     <= d_nxt;
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign tap_addr      = t_r;
  assign smp_idx       = j_r;
  assign cmd.ld_tap    = accept && (op_sample == OP_TAP);
  assign cmd.ld_smp    = accept && (op_sample == OP_SAMPLE);
  assign cmd.issue     = (state_r == ST_ISSUE);
  assign cmd.clear_acc = (state_r == ST_IDLE) || (state_r == ST_EMIT);
  assign cmd.emit      = (state_r == ST_EMIT);
  assign cmd.last_out  = last_out;
  assign cmd.clear_smp = (state_r == ST_EMIT) && last_out;

endmodule

`default_nettype wire

### hw/rtl/c1ds_datapath.sv
// c1ds_datapath: tap and sample memories, load counters, pipelined MAC,
// round/saturate and the output register. Depends on c1ds_pkg.
`default_nettype none

module c1ds_datapath
  import c1ds_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_TAPS    = 16,
  localparam int SAW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
  localparam int SCW  = $clog2(MAX_SAMPLES + 1),
  localparam int TAW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int TCW  = $clog2(MAX_TAPS + 1),
  localparam int JW   = $clog2(MAX_SAMPLES + MAX_TAPS) + 1,
  localparam int ACCW = PROD_WIDTH + $clog2(MAX_TAPS + 1) + 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire c1ds_in_t             in_item,
  input  wire c1ds_cmd_t            cmd,
  input  wire logic [TAW-1:0]       tap_addr,
  input  wire logic signed [JW-1:0] smp_idx,
  output logic [TCW-1:0]            tap_cnt,
  output logic [SCW-1:0]            smp_cnt,
  output logic                      out_strobe,
  output c1ds_out_t                 out_item
);

  localparam logic signed [ACCW:0] HALF = (ACCW + 1)'(ROUND_HALF);
  localparam logic signed [ACCW:0] QMAX = (ACCW + 1)'(SAMPLE_MAX);
  localparam logic signed [ACCW:0] QMIN = (ACCW + 1)'(SAMPLE_MIN);

  logic signed [SAMPLE_WIDTH-1:0] tap_mem [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] smp_mem [MAX_SAMPLES];

  logic [TCW-1:0]                 tap_cnt_r;
  logic                           taps_closed_r;
  logic [SCW-1:0]                 smp_cnt_r;

  logic                           tap_we;
  logic [TAW-1:0]                 tap_wa;
  logic                           smp_we;

  logic signed [SAMPLE_WIDTH-1:0] tap_q_r, smp_q_r;
  logic                           v1_r, v2_r;
  logic signed [PROD_WIDTH-1:0]   prod_r;
  logic signed [ACCW-1:0]         acc_r;

  logic                           pair_ok;
  logic signed [ACCW:0]           rnd;
  logic signed [ACCW:0]           quo;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  logic                           out_valid_r;
  c1ds_out_t                      out_r;

  // a tap after a closed kernel starts a fresh kernel at entry 0
  assign tap_we = cmd.ld_tap && (taps_closed_r || (tap_cnt_r < TCW'(MAX_TAPS)));
  assign tap_wa = taps_closed_r ? '0 : tap_cnt_r[TAW-1:0];
  assign smp_we = cmd.ld_smp && (smp_cnt_r < SCW'(MAX_SAMPLES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_cnt_r     <= '0;
      taps_closed_r <= 1'b0;
      smp_cnt_r     <= '0;
    end else begin
      if (cmd.ld_tap) begin
        taps_closed_r <= in_item.last;
        if (taps_closed_r) begin
          tap_cnt_r <= TCW'(1);
        end else if (tap_we) begin
          tap_cnt_r <= tap_cnt_r + 1'b1;
        end
      end
      if (cmd.clear_smp) begin
        smp_cnt_r <= '0;
      end else if (smp_we) begin
        smp_cnt_r <= smp_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_wa] <= in_item.value;
    end
    tap_q_r <= tap_mem[tap_addr];
  end

  always_ff @(posedge clk) begin
    if (smp_we) begin
      smp_mem[smp_cnt_r[SAW-1:0]] <= in_item.value;
    end
    smp_q_r <= smp_mem[smp_idx[SAW-1:0]];
  end

  // sample index outside the loaded set contributes nothing
  assign pair_ok = cmd.issue && (smp_idx >= 0) && (smp_idx < $signed(JW'(smp_cnt_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= pair_ok;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= tap_q_r * smp_q_r;
    if (cmd.clear_acc) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + {{(ACCW - PROD_WIDTH){prod_r[PROD_WIDTH-1]}}, prod_r};
    end
  end

  // round half up, then saturate to the sample format
  assign rnd = {acc_r[ACCW-1], acc_r} + HALF;
  assign quo = rnd >>> (SAMPLE_WIDTH - 1);

  always_comb begin
    priority if (quo > QMAX) begin
      sat = SAMPLE_WIDTH'(SAMPLE_MAX);
    end else if (quo < QMIN) begin
      sat = SAMPLE_WIDTH'(SAMPLE_MIN);
    end else begin
      sat = quo[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.filtered     <= sat;
      out_r.end_of_block <= cmd.last_out;
    end
  end

  assign tap_cnt    = tap_cnt_r;
  assign smp_cnt    = smp_cnt_r;
  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

endmodule

`default_nettype wire

### hw/rtl/conv1d_same_size_unit.sv
// conv1d_same_size_unit: top level of the same-size 1-D convolution unit.
// Instantiates c1ds_ctrl and c1ds_datapath; depends on c1ds_pkg.
//
// Usage:
//  - Input channel: an item (in_item: operation, value, last) is taken at a
//    rising edge where start is high and busy is low. Taps (operation 0) are
//    loaded first, last closes the kernel; a tap after a closed kernel starts
//    a new one. Samples (operation 1) follow; the kernel is kept across runs.
//  - Tap and sample loads leave busy low.
//  - The sample with last set starts a run: busy rises and stays high until
//    all results are out. One shared multiply-accumulate steps through the
//    taps, one tap per cycle, into a 3-stage read/multiply/accumulate pipe.
//  - Sequence: for each result the sequencer issues the T loaded taps,
//    drains the pipe, then emits into the output register that drives
//    out_strobe. A run of N samples gives N results.
//  - Result channel: out_item with out_strobe high for one cycle per result;
//    end_of_block marks the last of the run. The receiver cannot stall.
//  - Extra taps or samples beyond the store depth are dropped.
//  - Reset (rst_n low, synchronous) clears counts and the sequencer; the
//    tap and sample memories are not cleared.
`default_nettype none

module conv1d_same_size_unit
  import c1ds_pkg::*;
#(
  parameter int MAX_SAMPLES = 64,
  parameter int MAX_TAPS    = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire c1ds_in_t  in_item,
  output logic           out_strobe,
  output c1ds_out_t      out_item
);

  localparam int SCW = $clog2(MAX_SAMPLES + 1);
  localparam int TAW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int TCW = $clog2(MAX_TAPS + 1);
  localparam int JW  = $clog2(MAX_SAMPLES + MAX_TAPS) + 1;

  c1ds_cmd_t            cmd;
  logic [TAW-1:0]       tap_addr;
  logic signed [JW-1:0] smp_idx;
  logic [TCW-1:0]       tap_cnt;
  logic [SCW-1:0]       smp_cnt;

  c1ds_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_TAPS    (MAX_TAPS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op_sample (in_item.operation),
    .last_flag (in_item.last),
    .tap_cnt   (tap_cnt),
    .smp_cnt   (smp_cnt),
    .busy      (busy),
    .cmd       (cmd),
    .tap_addr  (tap_addr),
    .smp_idx   (smp_idx)
  );

  c1ds_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .MAX_TAPS    (MAX_TAPS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .tap_addr   (tap_addr),
    .smp_idx    (smp_idx),
    .tap_cnt    (tap_cnt),
    .smp_cnt    (smp_cnt),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

### hw/rtl/c1ds_checker.sv
// c1ds_checker: port-level assertions for conv1d_same_size_unit, bound
// to the top level below. Depends on c1ds_pkg.
`default_nettype none

module c1ds_checker
  import c1ds_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      start,
  input wire logic      busy,
  input wire c1ds_in_t  in_item,
  input wire logic      out_strobe,
  input wire c1ds_out_t out_item
);

  logic run_start;
  logic plain_load;

  assign run_start  = start && !busy && (in_item.operation == OP_SAMPLE) && in_item.last;
  assign plain_load = start && !busy && !((in_item.operation == OP_SAMPLE) && in_item.last);

  // minimum spacing between successive result strobes
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe ##1 !out_strobe)
    else $error("results closer than three cycles");

  // more results pending: still busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.end_of_block) |-> busy)
    else $error("idle before end of block");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_start |=> busy)
    else $error("final sample did not start a run");

  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    plain_load |=> !busy && !out_strobe)
    else $error("load item caused busy or a result");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("activity right after reset");

endmodule

bind conv1d_same_size_unit c1ds_checker u_c1ds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

`default_nettype wire
